### rtl/lapm_pkg.sv
// lapm_pkg: shared types, constants and tables of the logit refiner
// depends on nothing; imported by lapm_row_div and logit_apm_refiner_core
`default_nettype none

package lapm_pkg;

   localparam int MAX_CONTEXTS = 256;
   localparam int BIN_COUNT    = 33;
   localparam int FRAC_BITS    = 12;

   localparam int ONE_Q       = 1 << FRAC_BITS;
   localparam int SPAN_BITS   = FRAC_BITS + 4;
   localparam int HALF_BITS   = FRAC_BITS - 1;
   localparam int EDGE_MARGIN = (ONE_Q + 50) / 100;

   localparam int IN_W    = 16;
   localparam int CTX_W   = 32;
   localparam int LOGIT_W = 20;
   localparam int RATE_W  = 16;
   localparam int BLEND_W = 17;
   localparam int CNT_W   = 9;
   localparam int CSR_IDX_W = 2;

   localparam int ROW_BITS    = $clog2(MAX_CONTEXTS);
   localparam int BIN_BITS    = $clog2(BIN_COUNT);
   localparam int TABLE_DEPTH = MAX_CONTEXTS * BIN_COUNT;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int POS_W       = IN_W + BIN_BITS;

   localparam int X_LO = -8 * ONE_Q + EDGE_MARGIN;
   localparam int X_HI = 8 * ONE_Q - EDGE_MARGIN;

   localparam logic [CSR_IDX_W-1:0] CSR_CONTEXT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_AMOUNT  = 2'd2;

   typedef logic signed [LOGIT_W-1:0] logit_type;
   typedef logit_type ramp_table_type [BIN_COUNT];
   typedef logic [16:0] prob_type;

   typedef struct packed {
      logic                done;
      logic [ROW_BITS-1:0] rem;
   } div_status_type;

   function automatic ramp_table_type build_ramp();
      ramp_table_type t;
      for (int b = 0; b < BIN_COUNT; b++) begin
         t[b] = LOGIT_W'(-8 * ONE_Q +
                (b * (16 * ONE_Q) + (BIN_COUNT - 1) / 2) / (BIN_COUNT - 1));
      end
      return t;
   endfunction

   localparam ramp_table_type RAMP_TABLE = build_ramp();

   localparam prob_type LOGISTIC_POINTS [17] = '{
      17'd32768, 17'd40793, 17'd47911, 17'd53581, 17'd57724, 17'd60565,
      17'd62428, 17'd63615, 17'd64357, 17'd64816, 17'd65097, 17'd65269,
      17'd65374, 17'd65438, 17'd65476, 17'd65500, 17'd65514
   };

   function automatic logit_type sat_logit(input logic signed [23:0] v);
      logit_type r;
      if (v < -24'sd524288) begin
         r = -20'sd524288;
      end else if (v > 24'sd524287) begin
         r = 20'sd524287;
      end else begin
         r = v[LOGIT_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/lapm_ram.sv
// lapm_ram: generic simple dual-port ram, one write and one registered read
// depends on nothing
`default_nettype none

module lapm_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 8448
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/lapm_row_div.sv
// lapm_row_div: context modulo context count, four quotient bits per cycle
// depends on lapm_pkg
`default_nettype none

module lapm_row_div
   import lapm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CTX_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output div_status_type        status
);

   localparam int DIGITS = 4;
   localparam int STEPS  = CTX_W / DIGITS;
   localparam int STEP_W = $clog2(STEPS);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CTX_W-1:0]    dvd_ff, dvd_in;
   logic [CNT_W-1:0]    dvs_ff, dvs_in;
   logic [ROW_BITS-1:0] rem_ff, rem_in;
   logic [ROW_BITS-1:0] rem_next;

   always_comb begin
      logic [CNT_W-1:0] t;
      logic [ROW_BITS-1:0] r;
      r = rem_ff;
      for (int k = 0; k < DIGITS; k++) begin
         t = {r, dvd_ff[CTX_W-1-k]};
         if (t >= dvs_ff) begin
            t = t - dvs_ff;
         end
         r = t[ROW_BITS-1:0];
      end
      rem_next = r;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (run_ff) begin
         rem_in  = rem_next;
         dvd_in  = dvd_ff << DIGITS;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

endmodule

`default_nettype wire

### rtl/logit_apm_refiner_core.sv
// logit_apm_refiner_core: top level of the logit-domain adaptive probability map
// depends on lapm_pkg, lapm_ram, lapm_row_div
`default_nettype none

// The table (256 rows of 33 entries, 20 bits) sits in one ram with a registered
// read. After reset a clearing pass writes the per-row ramp, one entry a cycle,
// during which no beat is taken (csr writes are). A predict runs through the row
// divider (context modulo count, four bits a cycle, plus the handoff), two table
// reads, and four passes through the one shared multiplier; the last pass waits
// until the output register is free. A learn holds the block through the
// logistic, two reads, two update products and two write-backs through the
// single ram port. One item is in work at a time; a result waiting in the output
// register does not hold off the next beat.
module logit_apm_refiner_core
   import lapm_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_op,
   input  wire logic signed [IN_W-1:0]      req_mixer_logit,
   input  wire logic [CTX_W-1:0]            req_context_value,
   input  wire logic                        req_bit_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [LOGIT_W-1:0]        rsp_refined_logit,
   output logic signed [LOGIT_W-1:0]        rsp_map_logit,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [BLEND_W-1:0]          csr_data
);

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_RD0   = 4'd3;
   localparam logic [3:0] ST_RD1   = 4'd4;
   localparam logic [3:0] ST_INT   = 4'd5;
   localparam logic [3:0] ST_BL0   = 4'd6;
   localparam logic [3:0] ST_BL1   = 4'd7;
   localparam logic [3:0] ST_LLOG  = 4'd8;
   localparam logic [3:0] ST_LPROD = 4'd9;
   localparam logic [3:0] ST_LD0   = 4'd10;
   localparam logic [3:0] ST_LD1   = 4'd11;
   localparam logic [3:0] ST_LWR1  = 4'd12;

   localparam int ACC_W = 40;
   localparam int MUL_A = 35;
   localparam int MUL_B = 18;
   localparam int MUL_W = MUL_A + MUL_B;
   localparam int DLT_W = MUL_W - 36;

   logic [3:0]                state_ff, state_in;
   logic [ADDR_BITS-1:0]      init_addr_ff, init_addr_in;
   logic [BIN_BITS-1:0]       init_bin_ff, init_bin_in;
   logic [CNT_W-1:0]          count_ff;
   logic [RATE_W-1:0]         rate_ff;
   logic [BLEND_W-1:0]        blend_ff;
   logic signed [IN_W-1:0]    x_ff;
   logic [BIN_BITS-1:0]       bin_ff;
   logic [SPAN_BITS-1:0]      frac_ff;
   logic                      bit_ff;
   logic [ROW_BITS-1:0]       row_ff;
   logic [ADDR_BITS-1:0]      base_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logit_type                 map_ff;
   logic [ROW_BITS-1:0]       saved_row_ff;
   logic [BIN_BITS-1:0]       saved_bin_ff;
   logic [SPAN_BITS-1:0]      saved_frac_ff;
   logit_type                 saved_out_ff;
   prob_type                  p_ff;
   logic signed [MUL_A-1:0]   prod_ff;
   logit_type                 t0_ff, t1_ff;
   logic signed [DLT_W-1:0]   dlt_ff;
   logic                      rsp_valid_ff;
   logit_type                 rsp_refined_ff, rsp_map_ff;

   logic                      req_accept;
   logic                      out_free;
   div_status_type            div_status;
   logic [CNT_W-1:0]          cnt_use;
   logic signed [IN_W-1:0]    x_clamp;
   logic [IN_W-1:0]           x_off;
   logic [POS_W-1:0]          pos;
   logic [BIN_BITS-1:0]       bin_new;
   logic [BLEND_W-1:0]        blend_use;
   logic [BLEND_W-1:0]        frac_w0;
   logic [BLEND_W-1:0]        learn_w0;
   logic signed [MUL_A-1:0]   mul_a;
   logic [BLEND_W-1:0]        mul_b;
   logic signed [MUL_W-1:0]   mul_p;
   logic signed [ACC_W-1:0]   round_sum;
   logit_type                 round_sat;
   logic signed [DLT_W-1:0]   dlt_new;
   prob_type                  p_new;
   logic signed [MUL_B-1:0]   err;
   logic signed [MUL_A-1:0]   prod_new;
   logic                      mem_we;
   logic [ADDR_BITS-1:0]      mem_waddr, mem_raddr;
   logit_type                 mem_wdata, mem_rdata;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(256);
         rate_ff  <= RATE_W'(1311);
         blend_ff <= BLEND_W'(32768);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CONTEXT_COUNT: count_ff <= csr_data[CNT_W-1:0];
            CSR_LEARN_RATE:    rate_ff  <= csr_data[RATE_W-1:0];
            CSR_BLEND_AMOUNT:  blend_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         cnt_use = CNT_W'(1);
      end else if (count_ff > CNT_W'(MAX_CONTEXTS)) begin
         cnt_use = CNT_W'(MAX_CONTEXTS);
      end else begin
         cnt_use = count_ff;
      end
      blend_use = (blend_ff > BLEND_W'(65536)) ? BLEND_W'(65536) : blend_ff;
   end

   // clamp just inside +-8, then bin and fraction
   always_comb begin
      if (req_mixer_logit < IN_W'(X_LO)) begin
         x_clamp = IN_W'(X_LO);
      end else if (req_mixer_logit > IN_W'(X_HI)) begin
         x_clamp = IN_W'(X_HI);
      end else begin
         x_clamp = req_mixer_logit;
      end
      x_off = {~x_clamp[IN_W-1], x_clamp[IN_W-2:0]};
      pos   = POS_W'(x_off) * POS_W'(BIN_COUNT - 1);
      if (pos[POS_W-1:SPAN_BITS] > (POS_W - SPAN_BITS)'(BIN_COUNT - 2)) begin
         bin_new = BIN_BITS'(BIN_COUNT - 2);
      end else begin
         bin_new = pos[SPAN_BITS+BIN_BITS-1:SPAN_BITS];
      end
   end

   lapm_row_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept && !req_op),
      .dividend (req_context_value),
      .divisor  (cnt_use),
      .status   (div_status)
   );

   // logistic of the last output
   always_comb begin
      logic [LOGIT_W-1:0] mag;
      logic [3:0]         idx;
      logic [HALF_BITS-1:0] fr;
      logic [27:0]        step;
      prob_type           p;
      mag  = saved_out_ff[LOGIT_W-1] ? LOGIT_W'(-saved_out_ff) : saved_out_ff;
      idx  = mag[HALF_BITS+3:HALF_BITS];
      fr   = mag[HALF_BITS-1:0];
      step = 28'(LOGISTIC_POINTS[idx+5'd1] - LOGISTIC_POINTS[idx]) * 28'(fr);
      if (mag[LOGIT_W-1:FRAC_BITS+3] != '0) begin
         p = LOGISTIC_POINTS[16];
      end else begin
         p = LOGISTIC_POINTS[idx] +
             17'((step + 28'(1 << (HALF_BITS - 1))) >> HALF_BITS);
      end
      p_new = saved_out_ff[LOGIT_W-1] ? 17'(17'h10000 - p) : p;
   end

   assign err = bit_ff ? (MUL_B'(65536) - $signed({1'b0, p_ff}))
                       : -$signed({1'b0, p_ff});
   assign prod_new = MUL_A'($signed({1'b0, rate_ff}) * err);

   // shared multiplier
   assign frac_w0  = BLEND_W'(65536) - BLEND_W'(frac_ff);
   assign learn_w0 = BLEND_W'(65536) - BLEND_W'(saved_frac_ff);

   always_comb begin
      mul_a = MUL_A'(mem_rdata);
      mul_b = frac_w0;
      case (state_ff)
         ST_RD1: begin
            mul_a = MUL_A'(mem_rdata);
            mul_b = frac_w0;
         end
         ST_INT: begin
            mul_a = MUL_A'(mem_rdata);
            mul_b = BLEND_W'(frac_ff);
         end
         ST_BL0: begin
            mul_a = MUL_A'(x_ff);
            mul_b = BLEND_W'(65536) - blend_use;
         end
         ST_BL1: begin
            mul_a = MUL_A'(map_ff);
            mul_b = blend_use;
         end
         ST_LD0: begin
            mul_a = prod_ff;
            mul_b = learn_w0;
         end
         ST_LD1: begin
            mul_a = prod_ff;
            mul_b = BLEND_W'(saved_frac_ff);
         end
         default: ;
      endcase
   end

   assign mul_p     = mul_a * $signed({1'b0, mul_b});
   assign round_sum = acc_ff + mul_p[ACC_W-1:0] + ACC_W'(32768);
   assign round_sat = sat_logit(round_sum[ACC_W-1:16]);
   assign dlt_new   = DLT_W'((mul_p + MUL_W'(64'sd1 <<< 35)) >>> 36);

   // table ram port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = base_ff;
      mem_wdata = sat_logit(24'(t0_ff) + 24'(dlt_ff));
      mem_raddr = base_ff;
      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_addr_ff;
            mem_wdata = RAMP_TABLE[init_bin_ff];
         end
         ST_RD1, ST_LPROD: mem_raddr = base_ff + 1'b1;
         ST_LD1: mem_we = 1'b1;
         ST_LWR1: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff + 1'b1;
            mem_wdata = sat_logit(24'(t1_ff) + 24'(dlt_ff));
         end
         default: ;
      endcase
   end

   lapm_ram #(
      .WIDTH (LOGIT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      init_addr_in = init_addr_ff;
      init_bin_in  = init_bin_ff;
      unique case (state_ff)
         ST_INIT: begin
            init_addr_in = init_addr_ff + 1'b1;
            init_bin_in  = (init_bin_ff == BIN_BITS'(BIN_COUNT - 1)) ? '0
                                                                       : init_bin_ff + 1'b1;
            if (init_addr_ff == ADDR_BITS'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_op ? ST_LLOG : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_RD0;
            end
         end
         ST_RD0:   state_in = ST_RD1;
         ST_RD1:   state_in = ST_INT;
         ST_INT:   state_in = ST_BL0;
         ST_BL0:   state_in = ST_BL1;
         ST_BL1: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LLOG:  state_in = ST_LPROD;
         ST_LPROD: state_in = ST_LD0;
         ST_LD0:   state_in = ST_LD1;
         ST_LD1:   state_in = ST_LWR1;
         ST_LWR1:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_addr_ff  <= '0;
         init_bin_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         saved_row_ff  <= '0;
         saved_bin_ff  <= '0;
         saved_frac_ff <= '0;
         saved_out_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         init_bin_ff  <= init_bin_in;
         if (state_ff == ST_BL1 && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_INT) begin
            saved_row_ff  <= row_ff;
            saved_bin_ff  <= bin_ff;
            saved_frac_ff <= frac_ff;
            saved_out_ff  <= round_sat;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff    <= req_mixer_logit;
         bin_ff  <= bin_new;
         frac_ff <= pos[SPAN_BITS-1:0];
         bit_ff  <= req_bit_value;
         base_ff <= ADDR_BITS'(saved_row_ff) * ADDR_BITS'(BIN_COUNT) +
                    ADDR_BITS'(saved_bin_ff);
      end
      if (state_ff == ST_DIV && div_status.done) begin
         row_ff  <= div_status.rem;
         base_ff <= ADDR_BITS'(div_status.rem) * ADDR_BITS'(BIN_COUNT) +
                    ADDR_BITS'(bin_ff);
      end
      unique case (state_ff)
         ST_RD1, ST_BL0: acc_ff <= mul_p[ACC_W-1:0];
         ST_INT:   map_ff <= round_sat;
         ST_LLOG:  p_ff <= p_new;
         ST_LPROD: begin
            t0_ff   <= mem_rdata;
            prod_ff <= prod_new;
         end
         ST_LD0: begin
            t1_ff  <= mem_rdata;
            dlt_ff <= dlt_new;
         end
         ST_LD1: dlt_ff <= dlt_new;
         default: ;
      endcase
      if (state_ff == ST_BL1 && out_free) begin
         rsp_refined_ff <= round_sat;
         rsp_map_ff     <= map_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_refined_logit = rsp_refined_ff;
   assign rsp_map_logit     = rsp_map_ff;

`ifndef ASSERT_OFF
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("beat taken while an item is in work");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_INIT || state_ff == ST_LD1 || state_ff == ST_LWR1))
      else $error("table written outside clearing or learn");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_BL1)
      else $error("result raised outside blend stage");
`endif

endmodule

`default_nettype wire
